@@ src/cbpf_pkg.sv @@
// Package for the classic BPF program checker: opcodes, status codes, shared types.
// No dependencies; imported by every module of the block.
package cbpf_pkg;

	localparam int MAX_PROGRAM = 4096;
	localparam int POS_W       = $clog2(MAX_PROGRAM);
	localparam int LEN_W       = POS_W + 1;
	localparam int CFG_W       = 13;
	localparam int OP_W        = 16;
	localparam int OFS_W       = 8;
	localparam int IMM_W       = 32;
	localparam int JMP_W       = IMM_W + 2;

	localparam logic [IMM_W-1:0] SEC_DATA_SIZE = 32'd64;
	localparam logic [IMM_W-1:0] SHIFT_LIMIT   = 32'd32;

	// permitted classic BPF opcodes
	localparam logic [OP_W-1:0] OP_LD_IMM   = 16'h0000;
	localparam logic [OP_W-1:0] OP_LDX_IMM  = 16'h0001;
	localparam logic [OP_W-1:0] OP_ST       = 16'h0002;
	localparam logic [OP_W-1:0] OP_STX      = 16'h0003;
	localparam logic [OP_W-1:0] OP_ADD_K    = 16'h0004;
	localparam logic [OP_W-1:0] OP_JA       = 16'h0005;
	localparam logic [OP_W-1:0] OP_RET_K    = 16'h0006;
	localparam logic [OP_W-1:0] OP_TAX      = 16'h0007;
	localparam logic [OP_W-1:0] OP_ADD_X    = 16'h000c;
	localparam logic [OP_W-1:0] OP_SUB_K    = 16'h0014;
	localparam logic [OP_W-1:0] OP_JEQ_K    = 16'h0015;
	localparam logic [OP_W-1:0] OP_RET_A    = 16'h0016;
	localparam logic [OP_W-1:0] OP_SUB_X    = 16'h001c;
	localparam logic [OP_W-1:0] OP_JEQ_X    = 16'h001d;
	localparam logic [OP_W-1:0] OP_LD_W_ABS = 16'h0020;
	localparam logic [OP_W-1:0] OP_MUL_K    = 16'h0024;
	localparam logic [OP_W-1:0] OP_JGT_K    = 16'h0025;
	localparam logic [OP_W-1:0] OP_MUL_X    = 16'h002c;
	localparam logic [OP_W-1:0] OP_JGT_X    = 16'h002d;
	localparam logic [OP_W-1:0] OP_DIV_K    = 16'h0034;
	localparam logic [OP_W-1:0] OP_JGE_K    = 16'h0035;
	localparam logic [OP_W-1:0] OP_DIV_X    = 16'h003c;
	localparam logic [OP_W-1:0] OP_JGE_X    = 16'h003d;
	localparam logic [OP_W-1:0] OP_OR_K     = 16'h0044;
	localparam logic [OP_W-1:0] OP_JSET_K   = 16'h0045;
	localparam logic [OP_W-1:0] OP_OR_X     = 16'h004c;
	localparam logic [OP_W-1:0] OP_JSET_X   = 16'h004d;
	localparam logic [OP_W-1:0] OP_AND_K    = 16'h0054;
	localparam logic [OP_W-1:0] OP_AND_X    = 16'h005c;
	localparam logic [OP_W-1:0] OP_LD_MEM   = 16'h0060;
	localparam logic [OP_W-1:0] OP_LDX_MEM  = 16'h0061;
	localparam logic [OP_W-1:0] OP_LSH_K    = 16'h0064;
	localparam logic [OP_W-1:0] OP_LSH_X    = 16'h006c;
	localparam logic [OP_W-1:0] OP_RSH_K    = 16'h0074;
	localparam logic [OP_W-1:0] OP_RSH_X    = 16'h007c;
	localparam logic [OP_W-1:0] OP_LD_LEN   = 16'h0080;
	localparam logic [OP_W-1:0] OP_LDX_LEN  = 16'h0081;
	localparam logic [OP_W-1:0] OP_NEG      = 16'h0084;
	localparam logic [OP_W-1:0] OP_TXA      = 16'h0087;
	localparam logic [OP_W-1:0] OP_XOR_K    = 16'h00a4;
	localparam logic [OP_W-1:0] OP_XOR_X    = 16'h00ac;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_DIV_ZERO = 3'd1,
		ST_SHIFT    = 3'd2,
		ST_JUMP     = 3'd3,
		ST_BAD_OP   = 3'd4,
		ST_NO_RET   = 3'd5,
		ST_SKIPPED  = 3'd6
	} status_t;

	typedef struct packed {
		logic [OP_W-1:0]  opcode;
		logic [OFS_W-1:0] true_offset;
		logic [OFS_W-1:0] false_offset;
		logic [IMM_W-1:0] immediate;
	} item_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             error_seen;
		logic             fatal_seen;
	} chk_state_t;

	typedef struct packed {
		logic [OP_W-1:0]  fixed_opcode;
		logic [IMM_W-1:0] fixed_immediate;
		status_t          status;
		logic             program_end;
		logic             program_failed;
	} result_t;

	// length 0 acts as 1, anything above MAX_PROGRAM acts as MAX_PROGRAM
	function automatic logic [LEN_W-1:0] eff_length(input logic [CFG_W-1:0] n);
		logic [31:0] n32;
		n32 = 32'(n);
		if (n32 == 32'd0)
			n32 = 32'd1;
		if (n32 > 32'(MAX_PROGRAM))
			n32 = 32'(MAX_PROGRAM);
		return LEN_W'(n32);
	endfunction

endpackage

@@ src/cbpf_check.sv @@
// Single-pass decode and check of one instruction against the program state.
// Depends on cbpf_pkg for opcodes, status codes and the item/state/result types.
module cbpf_check import cbpf_pkg::*; (
	input  item_t            item,
	input  chk_state_t       state,
	input  logic [LEN_W-1:0] len,
	output result_t          res,
	output chk_state_t       state_nxt
);

	logic             last;
	logic [JMP_W-1:0] pc;
	logic [JMP_W-1:0] len_ext;
	status_t          body_status;
	logic [OP_W-1:0]  body_op;
	logic [IMM_W-1:0] body_imm;
	logic             err_nxt;
	logic             fatal_nxt;

	assign last    = (LEN_W'(state.position) + LEN_W'(1)) >= len;
	assign pc      = JMP_W'(state.position);
	assign len_ext = JMP_W'(len);

	always_comb begin
		body_op     = item.opcode;
		body_imm    = item.immediate;
		body_status = ST_OK;
		unique case (item.opcode) inside
			OP_LD_W_ABS, OP_LD_IMM, OP_LDX_IMM, OP_LD_MEM, OP_LDX_MEM, OP_ST, OP_STX,
			OP_ADD_K, OP_ADD_X, OP_SUB_K, OP_SUB_X, OP_MUL_K, OP_MUL_X, OP_DIV_X,
			OP_AND_K, OP_AND_X, OP_OR_K, OP_OR_X, OP_XOR_K, OP_XOR_X,
			OP_LSH_X, OP_RSH_X, OP_NEG, OP_TAX, OP_TXA, OP_RET_K, OP_RET_A: begin
				body_status = ST_OK;
			end
			OP_LD_LEN: begin
				body_op  = OP_LD_IMM;
				body_imm = SEC_DATA_SIZE;
			end
			OP_LDX_LEN: begin
				body_op  = OP_LDX_IMM;
				body_imm = SEC_DATA_SIZE;
			end
			OP_DIV_K: begin
				body_status = (item.immediate == '0) ? ST_DIV_ZERO : ST_OK;
			end
			OP_LSH_K, OP_RSH_K: begin
				body_status = (item.immediate >= SHIFT_LIMIT) ? ST_SHIFT : ST_OK;
			end
			OP_JA: begin
				body_status = ((JMP_W'(item.immediate) + pc + JMP_W'(1)) >= len_ext)
					? ST_JUMP : ST_OK;
			end
			OP_JEQ_K, OP_JEQ_X, OP_JGE_K, OP_JGE_X,
			OP_JGT_K, OP_JGT_X, OP_JSET_K, OP_JSET_X: begin
				body_status = (((JMP_W'(item.true_offset) + pc + JMP_W'(1)) >= len_ext) ||
					((JMP_W'(item.false_offset) + pc + JMP_W'(1)) >= len_ext))
					? ST_JUMP : ST_OK;
			end
			default: begin
				body_status = ST_BAD_OP;
			end
		endcase
	end

	always_comb begin
		res.fixed_opcode    = item.opcode;
		res.fixed_immediate = item.immediate;
		res.program_end     = last;
		err_nxt             = state.error_seen;
		fatal_nxt           = state.fatal_seen;
		if (state.fatal_seen) begin
			res.status = ST_SKIPPED;
		end else if (last) begin
			if (item.opcode == OP_RET_K || item.opcode == OP_RET_A) begin
				res.status = ST_OK;
			end else begin
				res.status = ST_NO_RET;
				fatal_nxt  = 1'b1;
			end
		end else begin
			res.status          = body_status;
			res.fixed_opcode    = body_op;
			res.fixed_immediate = body_imm;
			if (body_status == ST_BAD_OP)
				fatal_nxt = 1'b1;
			else if (body_status != ST_OK)
				err_nxt = 1'b1;
		end
		res.program_failed = err_nxt | fatal_nxt;

		if (last) begin
			state_nxt = '0;
		end else begin
			state_nxt.position   = state.position + POS_W'(1);
			state_nxt.error_seen = err_nxt;
			state_nxt.fatal_seen = fatal_nxt;
		end
	end

endmodule

@@ src/classic_bpf_program_checker_unit.sv @@
// Top level of the classic BPF program checker: input register, check, result register.
// Depends on cbpf_pkg and cbpf_check.
//
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_stall   | opcode, true_offset, false_offset, immediate
// out     | output    | out_valid / out_stall | fixed_opcode, fixed_immediate, status,
//         |           |                       | program_end, program_failed
// cfg     | input     | cfg_valid / cfg_ready | program_length
//
// One instruction per cycle sustained while the result is not stalled.
// The check is one combinational pass between the input and result registers,
// and the program position and error flags advance as an item enters the result register.
// Reset clears valids, program state and sets program_length to 1; cfg_ready is always high.
// A stalled result holds one more transaction in the input register before in_stall rises.
module classic_bpf_program_checker_unit import cbpf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [OP_W-1:0]  opcode,
	input  logic [OFS_W-1:0] true_offset,
	input  logic [OFS_W-1:0] false_offset,
	input  logic [IMM_W-1:0] immediate,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [OP_W-1:0]  fixed_opcode,
	output logic [IMM_W-1:0] fixed_immediate,
	output logic [2:0]       status,
	output logic             program_end,
	output logic             program_failed,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] program_length
);

	item_t            item_s1;
	logic             valid_s1;
	result_t          res_s2;
	logic             valid_s2;
	chk_state_t       state_q;
	logic [CFG_W-1:0] length_q;
	result_t          res;
	chk_state_t       state_nxt;
	logic             accept;
	logic             move;

	assign move      = valid_s1 & (~valid_s2 | ~out_stall);
	assign in_stall  = valid_s1 & valid_s2 & out_stall;
	assign accept    = in_valid & ~in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= CFG_W'(1);
		end else if (cfg_valid) begin
			length_q <= program_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			valid_s1 <= accept | (valid_s1 & ~move);
			valid_s2 <= move | (valid_s2 & out_stall);
			if (move)
				state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.opcode       <= opcode;
			item_s1.true_offset  <= true_offset;
			item_s1.false_offset <= false_offset;
			item_s1.immediate    <= immediate;
		end
		if (move)
			res_s2 <= res;
	end

	cbpf_check u_check (
		.item      (item_s1),
		.state     (state_q),
		.len       (eff_length(length_q)),
		.res       (res),
		.state_nxt (state_nxt)
	);

	assign out_valid       = valid_s2;
	assign fixed_opcode    = res_s2.fixed_opcode;
	assign fixed_immediate = res_s2.fixed_immediate;
	assign status          = res_s2.status;
	assign program_end     = res_s2.program_end;
	assign program_failed  = res_s2.program_failed;

endmodule

@@ src/cbpf_checker.sv @@
// Port-level assertions for the classic BPF program checker, bound to the top level.
// Depends on cbpf_pkg for widths and status codes.
module cbpf_checker import cbpf_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic [OP_W-1:0]  fixed_opcode,
	input logic [2:0]       status,
	input logic             program_failed
);

	logic out_xfer;

	assign out_xfer = out_valid & ~out_stall;

	// in_stall only when a held result backs up the input register
	a_stall_cause: assert property (@(posedge clk)
		in_stall |-> (out_valid && out_stall))
		else $error("in_stall without a stalled result");

	// nothing pending during reset or on the first edge after it
	a_reset_empty: assert property (@(posedge clk)
		(!arst_n || !$past(arst_n)) |-> (!out_valid && !in_stall))
		else $error("activity during reset");

	// any error or skip must be reflected in the failure flag
	a_failed_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && status != 3'(ST_OK)) |-> program_failed)
		else $error("error status without program_failed");

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(fixed_opcode)))
		else $error("stalled result changed");

endmodule

bind classic_bpf_program_checker_unit cbpf_checker u_cbpf_checker (.*);

@@ tb/classic_bpf_program_checker_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for classic_bpf_program_checker_unit: directed and random programs,
// bursty sender, stalling receiver, expected results predicted in a scoreboard class.
// Depends on cbpf_pkg and the RTL of classic_bpf_program_checker_unit.
module classic_bpf_program_checker_unit_tb;
	import cbpf_pkg::*;

	class program_scoreboard;
		logic [CFG_W-1:0] length_reg;
		int unsigned      pos;
		bit               err_seen;
		bit               fatal_seen;
		result_t          expected_verdicts [$];
		int unsigned      failures;

		function new();
			length_reg = 1;
			pos        = 0;
			err_seen   = 0;
			fatal_seen = 0;
			failures   = 0;
		endfunction

		function void set_length(logic [CFG_W-1:0] v);
			length_reg = v;
		endfunction

		function status_t classify_body(item_t it, int unsigned eff, inout result_t r);
			longint unsigned k64, p64, n64;
			k64 = it.immediate;
			p64 = pos;
			n64 = eff;
			case (it.opcode)
				OP_LD_W_ABS, OP_LD_IMM, OP_LDX_IMM, OP_LD_MEM, OP_LDX_MEM, OP_ST, OP_STX,
				OP_ADD_K, OP_ADD_X, OP_SUB_K, OP_SUB_X, OP_MUL_K, OP_MUL_X, OP_DIV_X,
				OP_AND_K, OP_AND_X, OP_OR_K, OP_OR_X, OP_XOR_K, OP_XOR_X, OP_LSH_X,
				OP_RSH_X, OP_NEG, OP_TAX, OP_TXA, OP_RET_K, OP_RET_A:
					return ST_OK;
				OP_LD_LEN: begin
					r.fixed_opcode    = OP_LD_IMM;
					r.fixed_immediate = SEC_DATA_SIZE;
					return ST_OK;
				end
				OP_LDX_LEN: begin
					r.fixed_opcode    = OP_LDX_IMM;
					r.fixed_immediate = SEC_DATA_SIZE;
					return ST_OK;
				end
				OP_DIV_K:
					return (it.immediate == 0) ? ST_DIV_ZERO : ST_OK;
				OP_LSH_K, OP_RSH_K:
					return (it.immediate >= SHIFT_LIMIT) ? ST_SHIFT : ST_OK;
				OP_JA:
					return (k64 + p64 + 1 >= n64) ? ST_JUMP : ST_OK;
				OP_JEQ_K, OP_JEQ_X, OP_JGE_K, OP_JGE_X, OP_JGT_K, OP_JGT_X,
				OP_JSET_K, OP_JSET_X:
					return (p64 + it.true_offset + 1 >= n64 ||
						p64 + it.false_offset + 1 >= n64) ? ST_JUMP : ST_OK;
				default:
					return ST_BAD_OP;
			endcase
		endfunction

		function result_t judge_instruction(item_t it);
			result_t     r;
			int unsigned eff;
			bit          last;
			status_t     st;
			if (length_reg == 0)
				eff = 1;
			else if (length_reg > MAX_PROGRAM)
				eff = MAX_PROGRAM;
			else
				eff = length_reg;
			last              = (pos + 1 >= eff);
			r.fixed_opcode    = it.opcode;
			r.fixed_immediate = it.immediate;
			if (fatal_seen) begin
				st = ST_SKIPPED;
			end else if (last) begin
				st = (it.opcode == OP_RET_K || it.opcode == OP_RET_A) ? ST_OK : ST_NO_RET;
				if (st == ST_NO_RET)
					fatal_seen = 1;
			end else begin
				st = classify_body(it, eff, r);
				if (st == ST_BAD_OP)
					fatal_seen = 1;
				else if (st != ST_OK)
					err_seen = 1;
			end
			r.status         = st;
			r.program_end    = last;
			r.program_failed = err_seen | fatal_seen;
			if (last) begin
				pos        = 0;
				err_seen   = 0;
				fatal_seen = 0;
			end else begin
				pos++;
			end
			return r;
		endfunction

		function void note_input(item_t it);
			expected_verdicts.push_back(judge_instruction(it));
		endfunction

		task report_mismatch(string msg);
			failures++;
			if (failures <= 200)
				$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		task check_result(result_t got);
			result_t exp;
			if (expected_verdicts.size() == 0) begin
				report_mismatch("result transaction with no expectation pending");
				return;
			end
			exp = expected_verdicts.pop_front();
			if (got.fixed_opcode !== exp.fixed_opcode)
				report_mismatch($sformatf("fixed_opcode %h, expected %h",
					got.fixed_opcode, exp.fixed_opcode));
			if (got.fixed_immediate !== exp.fixed_immediate)
				report_mismatch($sformatf("fixed_immediate %h, expected %h",
					got.fixed_immediate, exp.fixed_immediate));
			if (got.status !== exp.status)
				report_mismatch($sformatf("status %0d, expected %0d", got.status, exp.status));
			if (got.program_end !== exp.program_end)
				report_mismatch($sformatf("program_end %b, expected %b",
					got.program_end, exp.program_end));
			if (got.program_failed !== exp.program_failed)
				report_mismatch($sformatf("program_failed %b, expected %b",
					got.program_failed, exp.program_failed));
		endtask
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [OP_W-1:0]  opcode;
	logic [OFS_W-1:0] true_offset;
	logic [OFS_W-1:0] false_offset;
	logic [IMM_W-1:0] immediate;
	logic             out_valid;
	logic             out_stall;
	logic [OP_W-1:0]  fixed_opcode;
	logic [IMM_W-1:0] fixed_immediate;
	logic [2:0]       status;
	logic             program_end;
	logic             program_failed;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CFG_W-1:0] program_length;

	program_scoreboard sb;
	logic [OP_W-1:0]   permitted_ops [0:40];
	int unsigned       gen_pos;
	int unsigned       gen_eff;
	int unsigned       burst_left;
	int unsigned       random_sent;
	bit                hold_req;

	classic_bpf_program_checker_unit u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.opcode          (opcode),
		.true_offset     (true_offset),
		.false_offset    (false_offset),
		.immediate       (immediate),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.fixed_opcode    (fixed_opcode),
		.fixed_immediate (fixed_immediate),
		.status          (status),
		.program_end     (program_end),
		.program_failed  (program_failed),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.program_length  (program_length)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.set_length(program_length);
			if (in_valid && !in_stall)
				sb.note_input({opcode, true_offset, false_offset, immediate});
			if (out_valid && !out_stall)
				sb.check_result({fixed_opcode, fixed_immediate, status, program_end,
					program_failed});
		end
	end

	// receiver: switches between random stall patterns, long hold-off on request
	initial begin : receiver
		int unsigned mode;
		int unsigned span;
		out_stall = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(10, 80);
			repeat (span) begin
				@(posedge clk);
				if (hold_req) begin
					out_stall <= 1'b1;
					repeat (150) @(posedge clk);
					hold_req = 1'b0;
				end else begin
					case (mode)
						0: out_stall <= 1'b0;
						1: out_stall <= ($urandom_range(0, 99) < 30);
						2: out_stall <= ($urandom_range(0, 99) < 70);
						default: out_stall <= ~out_stall;
					endcase
				end
			end
		end
	end

	initial begin
		#10ms;
		$display("** classic_bpf_program_checker_unit: FAILED **");
		$finish;
	end

	task automatic send_item(input item_t it);
		opcode       <= it.opcode;
		true_offset  <= it.true_offset;
		false_offset <= it.false_offset;
		immediate    <= it.immediate;
		in_valid     <= 1'b1;
		do @(posedge clk); while (in_stall);
		gen_pos = (gen_pos + 1 >= gen_eff) ? 0 : gen_pos + 1;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(0, 12);
		end
	endtask

	task automatic send_fields(input logic [OP_W-1:0] op, input logic [OFS_W-1:0] jt,
		input logic [OFS_W-1:0] jf, input logic [IMM_W-1:0] k);
		send_item({op, jt, jf, k});
	endtask

	// wait until every transaction in flight has produced its result
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_verdicts.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_length(input logic [CFG_W-1:0] v);
		drain();
		program_length <= v;
		cfg_valid      <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (v == 0)
			gen_eff = 1;
		else if (v > MAX_PROGRAM)
			gen_eff = MAX_PROGRAM;
		else
			gen_eff = v;
	endtask

	function automatic item_t make_instruction(int unsigned pos, int unsigned eff);
		item_t            it;
		int unsigned      pick;
		int unsigned      bnd;
		logic [OFS_W-1:0] ofs_near;
		it.opcode       = permitted_ops[$urandom_range(0, 40)];
		it.true_offset  = 8'($urandom);
		it.false_offset = 8'($urandom);
		it.immediate    = $urandom;
		pick            = $urandom_range(0, 99);
		if (pos + 1 >= eff) begin
			if (pick < 85)
				it.opcode = pick[0] ? OP_RET_K : OP_RET_A;
			else if (pick >= 95)
				it.opcode = 16'($urandom);
			return it;
		end
		if (pick < 6)
			it.opcode = 16'($urandom);
		else if (pick < 12)
			it.opcode = 16'($urandom_range(0, 255));
		bnd = eff - pos - 1;
		case (it.opcode)
			OP_DIV_K:
				if ($urandom_range(0, 2) == 0)
					it.immediate = 0;
			OP_LSH_K, OP_RSH_K:
				case ($urandom_range(0, 3))
					0: it.immediate = 31;
					1: it.immediate = 32;
					2: it.immediate = $urandom_range(0, 40);
					default: ;
				endcase
			OP_JA:
				if ($urandom_range(0, 1) == 1)
					it.immediate = bnd + $urandom_range(0, 2) - 1;
			OP_JEQ_K, OP_JEQ_X, OP_JGT_K, OP_JGT_X, OP_JGE_K, OP_JGE_X,
			OP_JSET_K, OP_JSET_X:
				if (bnd <= 255 && $urandom_range(0, 3) != 0) begin
					it.true_offset  = 8'($urandom_range(0, bnd - 1));
					it.false_offset = 8'($urandom_range(0, bnd - 1));
					ofs_near        = 8'(bnd - 1 + $urandom_range(0, 1));
					if ($urandom_range(0, 1) == 1)
						it.true_offset = ofs_near;
					else
						it.false_offset = ofs_near;
				end
			default: ;
		endcase
		return it;
	endfunction

	initial begin
		int unsigned      phase;
		int unsigned      pick;
		int unsigned      n_items;
		logic [CFG_W-1:0] len;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		opcode         = '0;
		true_offset    = '0;
		false_offset   = '0;
		immediate      = '0;
		cfg_valid      = 1'b0;
		program_length = '0;
		hold_req       = 1'b0;
		gen_pos        = 0;
		gen_eff        = 1;
		burst_left     = 0;
		random_sent    = 0;
		permitted_ops  = '{OP_LD_IMM, OP_LDX_IMM, OP_ST, OP_STX, OP_ADD_K, OP_JA, OP_RET_K,
			OP_TAX, OP_ADD_X, OP_SUB_K, OP_JEQ_K, OP_RET_A, OP_SUB_X, OP_JEQ_X, OP_LD_W_ABS,
			OP_MUL_K, OP_JGT_K, OP_MUL_X, OP_JGT_X, OP_DIV_K, OP_JGE_K, OP_DIV_X, OP_JGE_X,
			OP_OR_K, OP_JSET_K, OP_OR_X, OP_JSET_X, OP_AND_K, OP_AND_X, OP_LD_MEM,
			OP_LDX_MEM, OP_LSH_K, OP_LSH_X, OP_RSH_K, OP_RSH_X, OP_LD_LEN, OP_LDX_LEN,
			OP_NEG, OP_TXA, OP_XOR_K, OP_XOR_X};
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset length of one: return passes, anything else is a missing return
		send_fields(OP_RET_K, 8'h00, 8'hff, 32'hffff_ffff);
		send_fields(OP_LD_W_ABS, 8'hff, 8'h00, 32'h0000_0000);
		// length zero behaves as one
		write_length(13'd0);
		send_fields(OP_RET_A, 8'hff, 8'hff, 32'h0);
		// rewrites, divide by zero, shift range, jump range, return after errors
		write_length(13'd8);
		send_fields(OP_LD_LEN, 8'h00, 8'h00, 32'hffff_ffff);
		send_fields(OP_LDX_LEN, 8'hff, 8'hff, 32'h0);
		send_fields(OP_DIV_K, 8'h00, 8'h00, 32'h0);
		send_fields(OP_LSH_K, 8'h00, 8'h00, 32'd32);
		send_fields(OP_RSH_K, 8'h00, 8'h00, 32'd31);
		send_fields(OP_JEQ_K, 8'h01, 8'h00, 32'h5a5a_a5a5);
		send_fields(OP_JA, 8'h00, 8'h00, 32'd1);
		send_fields(OP_RET_K, 8'h00, 8'h00, 32'h0);
		// unknown opcode above 8 bits, then skipped items pass through unchanged
		send_fields(OP_JGT_K, 8'h00, 8'hff, 32'h1);
		send_fields(16'h0106, 8'h00, 8'h00, 32'h0);
		send_fields(OP_DIV_K, 8'h00, 8'h00, 32'h0);
		send_fields(OP_LD_LEN, 8'h00, 8'h00, 32'h1234_5678);
		send_fields(16'hffff, 8'hff, 8'hff, 32'hffff_ffff);
		send_fields(OP_JA, 8'h00, 8'h00, 32'hffff_ffff);
		send_fields(OP_RET_A, 8'h00, 8'h00, 32'h0);
		send_fields(OP_RET_K, 8'h00, 8'h00, 32'h0);
		// last instruction is never rewritten
		write_length(13'd3);
		send_fields(OP_JA, 8'h00, 8'h00, 32'h0);
		send_fields(OP_JA, 8'h00, 8'h00, 32'h0);
		send_fields(OP_LD_LEN, 8'h00, 8'h00, 32'h0);

		phase = 0;
		while (random_sent < 750) begin
			case (phase)
				0: len = 13'd8191;
				1: len = 13'd4096;
				2: len = 13'd4097;
				3: len = 13'd2;
				4: len = 13'd0;
				default: begin
					pick = $urandom_range(0, 99);
					if (pick < 60)
						len = 13'($urandom_range(1, 12));
					else if (pick < 75)
						len = 13'($urandom_range(13, 300));
					else if (pick < 82)
						len = 13'($urandom_range(0, 1));
					else if (pick < 88)
						len = 13'd4096;
					else if (pick < 94)
						len = 13'($urandom_range(4097, 8191));
					else
						len = 13'd8191;
				end
			endcase
			write_length(len);
			if (gen_eff <= 12)
				n_items = gen_eff * $urandom_range(2, 6) + $urandom_range(0, gen_eff);
			else
				n_items = $urandom_range(20, 60);
			if (phase == 3 || phase % 7 == 5) begin
				hold_req = 1'b1;
				if (n_items < 24)
					n_items = 24;
			end
			repeat (n_items) begin
				send_item(make_instruction(gen_pos, gen_eff));
				random_sent++;
			end
			phase++;
		end

		drain();
		repeat (8) @(posedge clk);
		if (sb.expected_verdicts.size() != 0)
			sb.report_mismatch($sformatf("%0d expected results never arrived",
				sb.expected_verdicts.size()));
		if (sb.failures == 0)
			$display("** classic_bpf_program_checker_unit: PASSED **");
		else
			$display("** classic_bpf_program_checker_unit: FAILED **");
		$finish;
	end

endmodule
